// ===== design/etx_link_quality_estimator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the link quality estimator
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ETX_LINK_QUALITY_ESTIMATOR_CORE_ASSERT_SVH
`define ETX_LINK_QUALITY_ESTIMATOR_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define ETX_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the next
`define ETX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/etx_lqe_pkg.sv =====
// ----------------------------------------------------------------------------
// etx_lqe_pkg
// Constants, codes and controller/datapath types of the link quality estimator.
// ----------------------------------------------------------------------------
package etx_lqe_pkg;

    // Algorithm constants
    localparam int QUICKSTART_STEPS = 12;
    localparam int QUICKSTART_ALPHA = 16384;
    localparam int MIN_LQ           = 6554;
    localparam int COST_SCALE       = 1024;
    localparam int COST_BROKEN      = 1048576;
    localparam int FRAC_BITS        = 16;
    localparam int MLQ_RESET        = 65536;
    localparam int LQ_MAX           = 65535;

    // Field widths
    localparam int LQ_W     = 16;
    localparam int ALPHA_W  = 16;
    localparam int MULT_W   = 17;
    localparam int MLQ_W    = 24;
    localparam int WARM_W   = 4;
    localparam int COST_W   = 21;
    localparam int ONE_W    = FRAC_BITS + 1;

    // Arithmetic widths
    localparam int PROD_W   = LQ_W + ONE_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int DEN_W    = 2 * LQ_W;
    localparam int SCALE_W  = $clog2(COST_SCALE + 1);
    localparam int NUM_W    = MLQ_W + SCALE_W;
    localparam int DVD_W    = NUM_W + FRAC_BITS;
    localparam int CMP_W    = DVD_W + DEN_W;
    localparam int QUOT_W   = $clog2(COST_BROKEN) + 1;
    localparam int CNT_W    = $clog2(QUOT_W);

    // Configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    typedef enum logic [0:0] {
        REG_AGING_FACTOR = 1'b0
    } reg_idx_t;

    typedef enum logic [0:0] {
        OP_HELLO   = 1'b0,
        OP_FOREIGN = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DEN,
        ST_CHK,
        ST_DIV,
        ST_FIN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take_hello;
        logic take_foreign;
        logic mul_en;
        logic upd_en;
        logic den_en;
        logic chk_en;
        logic div_step;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic quick;
        logic div_last;
        logic out_busy;
    } status_t;

endpackage

// ===== design/etx_lqe_regs.sv =====
// ----------------------------------------------------------------------------
// etx_lqe_regs
// APB register file holding the aging factor.
// ----------------------------------------------------------------------------
module etx_lqe_regs
    import etx_lqe_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    output logic [ALPHA_W-1:0]  aging_factor
);

    logic [ALPHA_W-1:0] aging_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register write, word index in paddr[2]
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aging_reg <= ALPHA_W'(3277);
        end else if (wr_en) begin
            case (paddr[2])
                REG_AGING_FACTOR: aging_reg <= pwdata[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (paddr[2])
            REG_AGING_FACTOR: prdata = PDATA_W'(aging_reg);
            default:          prdata = '0;
        endcase
    end

    assign aging_factor = aging_reg;

endmodule

// ===== design/etx_lqe_ctrl.sv =====
// ----------------------------------------------------------------------------
// etx_lqe_ctrl
// Sequencer: request intake, quality update, cost division, result handoff.
// ----------------------------------------------------------------------------
`include "etx_link_quality_estimator_core_assert.svh"

module etx_lqe_ctrl
    import etx_lqe_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_operation,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == OP_FOREIGN) begin
                        cmd.take_foreign = 1'b1;
                    end else begin
                        cmd.take_hello = 1'b1;
                        state_next     = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd_en = 1'b1;
                state_next = ST_DEN;
            end
            ST_DEN: begin
                cmd.den_en = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cmd.chk_en = 1'b1;
                state_next = status.quick ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) state_next = ST_FIN;
            end
            ST_FIN: begin
                // wait for the output register to free up
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `ETX_ASSERT_NEXT(a_hello_blocks_intake, s_valid && s_ready && (s_operation == OP_HELLO), !s_ready, "hello request did not block intake")
    `ETX_ASSERT_NEXT(a_div_ends_in_fin, (state_reg == ST_DIV) && status.div_last, state_reg == ST_FIN, "division did not finish")

endmodule

// ===== design/etx_lqe_dp.sv =====
// ----------------------------------------------------------------------------
// etx_lqe_dp
// Datapath: link state, EMA update, restoring cost divider, output register.
// ----------------------------------------------------------------------------
`include "etx_link_quality_estimator_core_assert.svh"

module etx_lqe_dp
    import etx_lqe_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [ALPHA_W-1:0]  aging_factor,
    input  logic                s_hello_lost,
    input  logic [MULT_W-1:0]   s_loss_multiplier,
    input  logic                s_foreign_present,
    input  logic [LQ_W-1:0]     s_foreign_quality,
    input  logic [MLQ_W-1:0]    s_distance_multiplier,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COST_W-1:0]   m_link_cost,
    output logic [LQ_W-1:0]     m_local_quality
);

    // link state
    logic [LQ_W-1:0]    lq_reg, nlq_reg;
    logic [MLQ_W-1:0]   mlq_reg;
    logic [WARM_W-1:0]  warm_reg;
    logic               out_valid_reg;

    // per-request work registers
    logic [ALPHA_W-1:0] alpha_reg;
    logic               lost_reg;
    logic [MULT_W-1:0]  mult_reg;
    logic [PROD_W-1:0]  keep_reg, gain_reg;
    logic [DEN_W-1:0]   den_reg;
    logic               low_reg;
    logic               quick_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [QUOT_W-1:0]  dvd_reg, quot_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [COST_W-1:0]  cost_out_reg;
    logic [LQ_W-1:0]    lq_out_reg;

    logic [ALPHA_W-1:0] alpha_sel;
    logic [ONE_W-1:0]   one_minus;
    logic [ACC_W-1:0]   acc_sum, acc_shift;
    logic [LQ_W-1:0]    lq_next;
    logic [CMP_W-1:0]   n_wide, d_wide;
    logic               quick;
    logic [DEN_W:0]     trial;
    logic               trial_ge;
    logic [QUOT_W-1:0]  cost_sat;

    // quickstart weight during warm-up
    assign alpha_sel = (warm_reg < WARM_W'(QUICKSTART_STEPS)) ?
                       ALPHA_W'(QUICKSTART_ALPHA) : aging_factor;
    assign one_minus = ONE_W'(1 << FRAC_BITS) - ONE_W'(alpha_reg);

    // EMA sum, scale back and saturate
    assign acc_sum   = ACC_W'(keep_reg) + ACC_W'(gain_reg);
    assign acc_shift = acc_sum >> FRAC_BITS;
    assign lq_next   = (acc_shift > ACC_W'(LQ_MAX)) ? LQ_W'(LQ_MAX) : acc_shift[LQ_W-1:0];

    // dividend mlq*scale*one, overflow when quotient needs more than QUOT_W bits
    assign n_wide = CMP_W'(NUM_W'(mlq_reg) * NUM_W'(COST_SCALE)) << FRAC_BITS;
    assign d_wide = CMP_W'(den_reg) << QUOT_W;
    assign quick  = low_reg || (den_reg == '0) || (n_wide >= d_wide);

    // one restoring step
    assign trial    = {rem_reg, dvd_reg[QUOT_W-1]};
    assign trial_ge = trial >= {1'b0, den_reg};

    // saturation and floor of one
    always_comb begin
        if (quot_reg > QUOT_W'(COST_BROKEN)) cost_sat = QUOT_W'(COST_BROKEN);
        else if (quot_reg == '0)             cost_sat = QUOT_W'(1);
        else                                 cost_sat = quot_reg;
    end

    assign status.quick    = quick;
    assign status.div_last = (cnt_reg == '0);
    assign status.out_busy = out_valid_reg && !m_ready;

    // link state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lq_reg        <= '0;
            nlq_reg       <= '0;
            mlq_reg       <= MLQ_W'(MLQ_RESET);
            warm_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.take_foreign) begin
                if (s_foreign_present) begin
                    nlq_reg <= s_foreign_quality;
                    mlq_reg <= s_distance_multiplier;
                end else begin
                    nlq_reg <= '0;
                end
            end
            if (cmd.take_hello && (warm_reg < WARM_W'(QUICKSTART_STEPS))) begin
                warm_reg <= warm_reg + WARM_W'(1);
            end
            if (cmd.upd_en) lq_reg <= lq_next;
            if (cmd.load_out)  out_valid_reg <= 1'b1;
            else if (m_ready)  out_valid_reg <= 1'b0;
        end
    end

    // work registers
    always_ff @(posedge aclk) begin
        if (cmd.take_hello) begin
            alpha_reg <= alpha_sel;
            lost_reg  <= s_hello_lost;
            mult_reg  <= s_loss_multiplier;
        end
        if (cmd.mul_en) begin
            keep_reg <= PROD_W'(lq_reg) * PROD_W'(one_minus);
            gain_reg <= lost_reg ? '0 : PROD_W'(alpha_reg) * PROD_W'(mult_reg);
        end
        if (cmd.den_en) begin
            den_reg <= DEN_W'(lq_reg) * DEN_W'(nlq_reg);
            low_reg <= (lq_reg < LQ_W'(MIN_LQ)) || (nlq_reg < LQ_W'(MIN_LQ));
        end
        if (cmd.chk_en) begin
            quick_reg <= quick;
            rem_reg   <= DEN_W'(n_wide >> QUOT_W);
            dvd_reg   <= n_wide[QUOT_W-1:0];
            quot_reg  <= '0;
            cnt_reg   <= CNT_W'(QUOT_W - 1);
        end
        if (cmd.div_step) begin
            rem_reg  <= trial_ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quot_reg <= {quot_reg[QUOT_W-2:0], trial_ge};
            dvd_reg  <= dvd_reg << 1;
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
        if (cmd.load_out) begin
            cost_out_reg <= quick_reg ? COST_W'(COST_BROKEN) : COST_W'(cost_sat);
            lq_out_reg   <= lq_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_link_cost     = cost_out_reg;
    assign m_local_quality = lq_out_reg;

    `ETX_ASSERT_HOLDS(a_rem_below_den, !cmd.div_step || (rem_reg < den_reg), "partial remainder reached divisor")
    `ETX_ASSERT_HOLDS(a_cost_range, !out_valid_reg || ((cost_out_reg != '0) && (cost_out_reg <= COST_W'(COST_BROKEN))), "link cost out of range")

endmodule

// ===== design/etx_link_quality_estimator_core.sv =====
// ----------------------------------------------------------------------------
// etx_link_quality_estimator_core
// ETX-style link quality estimator and link cost unit for one link.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (valid/ready). A hello-slot request ages
//   the local quality by an EMA and yields one result on the m_ channel: the
//   link cost and the updated local quality. A foreign-hello request stores
//   the neighbour quality and mobility multiplier and yields no result.
//   One request is in work at a time. A foreign hello is taken in the idle
//   state. A hello slot passes the multiply, update, denominator and check
//   states, a one-bit-per-cycle restoring divider of 21 steps and handoff;
//   if the cost is settled early (quality below minimum or cost saturated)
//   the divider is skipped. The result sits in an output register, so the
//   next request is accepted while a result waits; a stalled receiver holds
//   the sequencer only when a second result is ready to be loaded. The aging
//   factor is written over APB at address 0 while the block is idle; the
//   user must keep to this, the block itself does not enforce it. Reset
//   (aresetn low, synchronous) clears qualities and warm-up count, sets the
//   mobility multiplier to 1.0 and the aging factor to 3277.
// ----------------------------------------------------------------------------
module etx_link_quality_estimator_core
    import etx_lqe_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic                s_hello_lost,
    input  logic [MULT_W-1:0]   s_loss_multiplier,
    input  logic                s_foreign_present,
    input  logic [LQ_W-1:0]     s_foreign_quality,
    input  logic [MLQ_W-1:0]    s_distance_multiplier,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COST_W-1:0]   m_link_cost,
    output logic [LQ_W-1:0]     m_local_quality
);

    logic [ALPHA_W-1:0] aging_factor;
    cmd_t               cmd;
    status_t            status;

    etx_lqe_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .aging_factor (aging_factor)
    );

    etx_lqe_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    etx_lqe_dp u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .status                (status),
        .aging_factor          (aging_factor),
        .s_hello_lost          (s_hello_lost),
        .s_loss_multiplier     (s_loss_multiplier),
        .s_foreign_present     (s_foreign_present),
        .s_foreign_quality     (s_foreign_quality),
        .s_distance_multiplier (s_distance_multiplier),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_link_cost           (m_link_cost),
        .m_local_quality       (m_local_quality)
    );

endmodule

// ===== dv/tb_etx_link_quality_estimator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_etx_link_quality_estimator_core
// Self-checking bench for the ETX link quality estimator. Hello-slot and
// foreign-hello requests are driven on the s_ channel. A tracker class keeps
// its own copy of the link state and the aging factor, and predicts the cost
// and local quality of each hello slot. Results on the m_ channel are checked
// in order. Both sides idle at random. The aging factor is reprogrammed over
// APB between phases and read back.
// ----------------------------------------------------------------------------
module tb_etx_link_quality_estimator_core;
    import etx_lqe_pkg::*;

    localparam longint unsigned Q_ONE = 64'd1 << FRAC_BITS;
    localparam int SETTLE_CYCLES    = 40;    // covers a hello slot's run to m_valid
    localparam int DRAIN_LIMIT      = 4000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_REQUESTS   = 100;

    typedef struct packed {
        bit [COST_W-1:0] cost;
        bit [LQ_W-1:0]   quality;
    } cost_result_t;

    // Link state tracker: predicts each hello-slot result and checks it
    class link_cost_tracker;
        bit [LQ_W-1:0]    lq;
        bit [LQ_W-1:0]    nlq;
        bit [MLQ_W-1:0]   mlq;
        bit [WARM_W-1:0]  warm;
        bit [ALPHA_W-1:0] aging;
        cost_result_t     pending_costs[$];
        int unsigned      mismatches;

        function new();
            lq         = '0;
            nlq        = '0;
            mlq        = MLQ_W'(MLQ_RESET);
            warm       = '0;
            aging      = ALPHA_W'(3277);
            mismatches = 0;
        endfunction

        function void set_aging(bit [ALPHA_W-1:0] value);
            aging = value;
        endfunction

        function void flag(string what, longint unsigned want, logic [31:0] got);
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        endfunction

        // Cost = mlq * COST_SCALE / (lq * nlq), with the broken-link rules
        function bit [COST_W-1:0] predict_cost();
            longint unsigned den, num, whole, rest, cost;
            if (lq < MIN_LQ || nlq < MIN_LQ)
                return COST_W'(COST_BROKEN);
            den = 64'(lq) * 64'(nlq);
            if (den == 0)
                return COST_W'(COST_BROKEN);
            num   = 64'(mlq) * COST_SCALE;
            whole = num / den;
            rest  = num % den;
            if (whole >= COST_BROKEN)
                return COST_W'(COST_BROKEN);
            cost = (whole << FRAC_BITS) + ((rest << FRAC_BITS) / den);
            if (cost > COST_BROKEN)
                cost = COST_BROKEN;
            if (cost == 0)
                cost = 1;
            return cost[COST_W-1:0];
        endfunction

        function void note_request(op_t op, logic lost, logic [MULT_W-1:0] mult,
                                   logic present, logic [LQ_W-1:0] fq,
                                   logic [MLQ_W-1:0] dm);
            longint unsigned alpha, acc;
            cost_result_t    res;
            // foreign hello: store neighbour data, no result
            if (op == OP_FOREIGN) begin
                if (present) begin
                    nlq = fq;
                    mlq = dm;
                end else begin
                    nlq = '0;
                end
                return;
            end
            // hello slot: EMA update, quickstart weight during warm-up
            alpha = aging;
            if (warm < QUICKSTART_STEPS) begin
                alpha = QUICKSTART_ALPHA;
                warm  = warm + 1'b1;
            end
            if (alpha > Q_ONE)
                alpha = Q_ONE;
            acc = 64'(lq) * (Q_ONE - alpha);
            if (!lost)
                acc += alpha * 64'(mult);
            acc = acc >> FRAC_BITS;
            if (acc > LQ_MAX)
                acc = LQ_MAX;
            lq          = acc[LQ_W-1:0];
            res.cost    = predict_cost();
            res.quality = lq;
            pending_costs.push_back(res);
        endfunction

        function void check_result(logic [COST_W-1:0] cost, logic [LQ_W-1:0] quality);
            cost_result_t want;
            if (pending_costs.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual cost %0d quality %0d",
                         $time, cost, quality);
                mismatches++;
                return;
            end
            want = pending_costs.pop_front();
            if (cost !== want.cost)
                flag("link_cost", want.cost, 32'(cost));
            if (quality !== want.quality)
                flag("local_quality", want.quality, 32'(quality));
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic                s_operation;
    logic                s_hello_lost;
    logic [MULT_W-1:0]   s_loss_multiplier;
    logic                s_foreign_present;
    logic [LQ_W-1:0]     s_foreign_quality;
    logic [MLQ_W-1:0]    s_distance_multiplier;
    logic                m_valid;
    logic                m_ready;
    logic [COST_W-1:0]   m_link_cost;
    logic [LQ_W-1:0]     m_local_quality;

    link_cost_tracker costs;
    bit idle_on   = 1'b1;   // random gaps on both sides
    bit long_hold = 1'b0;   // receiver stalls for a long stretch when set

    etx_link_quality_estimator_core dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_operation           (s_operation),
        .s_hello_lost          (s_hello_lost),
        .s_loss_multiplier     (s_loss_multiplier),
        .s_foreign_present     (s_foreign_present),
        .s_foreign_quality     (s_foreign_quality),
        .s_distance_multiplier (s_distance_multiplier),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_link_cost           (m_link_cost),
        .m_local_quality       (m_local_quality)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Monitor: note accepted requests, check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                costs.note_request(op_t'(s_operation), s_hello_lost, s_loss_multiplier,
                                   s_foreign_present, s_foreign_quality,
                                   s_distance_multiplier);
            if (m_valid && m_ready)
                costs.check_result(m_link_cost, m_local_quality);
        end
    end

    // Result receiver: random bursts and gaps, plus one long hold-off
    initial begin
        int unsigned burst, gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (long_hold) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge aclk);
                long_hold = 1'b0;
            end
            burst = $urandom_range(1, 20);
            @(negedge aclk);
            m_ready <= 1'b1;
            repeat (burst - 1) @(negedge aclk);
            gap = idle_on ? next_gap() : 0;
            if (gap != 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    end

    // Offer one request after a random gap and wait until it is taken
    task automatic offer_request(input op_t op, input logic lost,
                                 input logic [MULT_W-1:0] mult, input logic present,
                                 input logic [LQ_W-1:0] fq, input logic [MLQ_W-1:0] dm);
        int unsigned gap;
        gap = idle_on ? next_gap() : 0;
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_operation           <= op;
        s_hello_lost          <= lost;
        s_loss_multiplier     <= mult;
        s_foreign_present     <= present;
        s_foreign_quality     <= fq;
        s_distance_multiplier <= dm;
        s_valid               <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hello slot; the foreign fields carry noise
    task automatic send_hello(input logic lost, input logic [MULT_W-1:0] mult);
        offer_request(OP_HELLO, lost, mult, 1'($urandom), LQ_W'($urandom),
                      MLQ_W'($urandom));
    endtask

    // Foreign hello; the loss fields carry noise
    task automatic send_foreign(input logic present, input logic [LQ_W-1:0] fq,
                                input logic [MLQ_W-1:0] dm);
        offer_request(OP_FOREIGN, 1'($urandom), MULT_W'($urandom), present, fq, dm);
    endtask

    // Mostly well-formed traffic: healthy neighbour data, received hellos
    task automatic send_random_request();
        int unsigned r;
        logic [LQ_W-1:0]   fq;
        logic [MLQ_W-1:0]  dm;
        logic [MULT_W-1:0] mult;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                fq = LQ_W'($urandom_range(MIN_LQ, LQ_MAX));
            else if (r < 85)
                fq = LQ_W'($urandom_range(0, MIN_LQ - 1));
            else
                fq = LQ_W'($urandom_range(0, LQ_MAX));
            r = $urandom_range(0, 99);
            if (r < 40)
                dm = MLQ_W'($urandom_range(32768, 262144));
            else if (r < 70)
                dm = MLQ_W'($urandom_range(0, 24'hFFFFFF));
            else if (r < 80)
                dm = '0;
            else if (r < 90)
                dm = 24'hFFFFFF;
            else
                dm = MLQ_W'($urandom_range(0, 1024));
            send_foreign($urandom_range(0, 9) != 0, fq, dm);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60)
                mult = MULT_W'($urandom_range(49152, 65536));
            else if (r < 80)
                mult = 17'd65536;
            else
                mult = MULT_W'($urandom_range(0, 65536));
            send_hello($urandom_range(0, 4) == 0, mult);
        end
    endtask

    // Stop offering, wait for every expected result, then let the block settle
    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (costs.pending_costs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input bit wr, input reg_idx_t idx,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (wr)
            costs.set_aging(wdata[ALPHA_W-1:0]);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic readback_aging();
        logic [PDATA_W-1:0] rd;
        apb_access(1'b0, REG_AGING_FACTOR, '0, rd);
        if (rd !== PDATA_W'(costs.aging))
            costs.flag("aging_factor readback", costs.aging, rd);
    endtask

    task automatic program_aging(input bit [ALPHA_W-1:0] value);
        logic [PDATA_W-1:0] rd;
        drain_results();
        apb_access(1'b1, REG_AGING_FACTOR, PDATA_W'(value), rd);
        readback_aging();
    endtask

    // Stimulus
    initial begin
        bit [ALPHA_W-1:0] phase_aging [8];
        aresetn               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        s_valid               = 1'b0;
        s_operation           = OP_HELLO;
        s_hello_lost          = 1'b0;
        s_loss_multiplier     = '0;
        s_foreign_present     = 1'b0;
        s_foreign_quality     = '0;
        s_distance_multiplier = '0;
        costs = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        readback_aging();

        // Directed: warm-up with quickstart weight, field extremes, edge cases
        send_hello(1'b0, 17'd65536);                 // no neighbour yet: broken
        send_foreign(1'b1, 16'hFFFF, 24'd65536);
        send_hello(1'b0, 17'd65536);
        send_hello(1'b0, 17'd0);
        send_foreign(1'b1, 16'hFFFF, 24'd0);         // zero mobility: cost floors to 1
        send_hello(1'b0, 17'd65536);
        send_foreign(1'b1, 16'(MIN_LQ), 24'hFFFFFF);
        send_hello(1'b1, MULT_W'($urandom));         // lost hello, cost saturates
        send_foreign(1'b0, 16'hFFFF, 24'h123456);    // no data: nlq cleared, mlq kept
        send_hello(1'b0, 17'd65536);
        send_foreign(1'b1, 16'(MIN_LQ - 1), 24'd65536);
        send_hello(1'b0, 17'd65536);
        send_foreign(1'b1, 16'd0, 24'd65536);
        send_foreign(1'b1, 16'hFFFF, 24'd65536);
        send_hello(1'b0, 17'd65536);
        send_hello(1'b1, 17'd65536);
        send_hello(1'b0, 17'd65536);
        send_hello(1'b0, 17'd65536);
        send_hello(1'b0, 17'h1FFFF);                 // last quickstart step
        program_aging(16'hFFFF);
        send_hello(1'b0, 17'h1FFFF);                 // quality overflow saturates
        send_hello(1'b0, 17'd65536);
        send_foreign(1'b1, 16'hFFFF, 24'hFFFFFF);
        send_hello(1'b0, 17'd65536);
        program_aging(16'd0);
        send_hello(1'b0, 17'd0);                     // zero weight: quality frozen
        send_hello(1'b1, 17'd0);

        // Random phases, one aging factor each
        phase_aging = '{16'd3277, 16'd1, 16'hFFFF, 16'd32768,
                        16'($urandom), 16'd0, 16'($urandom), 16'hFFFE};
        for (int p = 0; p < 8; p++) begin
            program_aging(phase_aging[p]);
            idle_on = (p != 2) && (p != 5);
            if (p == 2)
                long_hold = 1'b1;   // back up the block while requests keep coming
            repeat (PHASE_REQUESTS) send_random_request();
        end
        idle_on = 1'b1;

        drain_results();
        if (costs.pending_costs.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     costs.pending_costs.size());
            costs.mismatches++;
        end
        if (costs.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/etx_lqe_pkg.sv
design/etx_lqe_regs.sv
design/etx_lqe_ctrl.sv
design/etx_lqe_dp.sv
design/etx_link_quality_estimator_core.sv
dv/tb_etx_link_quality_estimator_core.sv
